/* hw/rtl/gha_pkg.sv */
// gha_pkg: shared types and constants for the generational handle allocator
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package gha_pkg;

	localparam int SLOTS    = 256;
	localparam int SLOT_W   = 8;
	localparam int GRP_SZ   = 16;
	localparam int GRP_N    = SLOTS / GRP_SZ;
	localparam int GRP_W    = 4;
	localparam int POS_W    = 4;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;
	localparam int HANDLE_W = 24;
	localparam int HGEN_W   = HANDLE_W - SLOT_W;
	localparam int AMOUNT_W = 32;
	localparam int USAGE_W  = 40;
	localparam int LOCK_W   = 16;
	localparam logic [LOCK_W-1:0] LOCK_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 3'd0,
		OP_FREE    = 3'd1,
		OP_RESIZE  = 3'd2,
		OP_LOCK    = 3'd3,
		OP_UNLOCK  = 3'd4,
		OP_INSPECT = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_NO_FREE      = 3'd1,
		ST_BAD_HANDLE   = 3'd2,
		ST_LOCKED       = 3'd3,
		ST_NOT_LOCKED   = 3'd4,
		ST_FREED_LOCKED = 3'd5,
		ST_LOCK_SAT     = 3'd6
	} status_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/gha_req_if.sv */
// gha_req_if: request channel, valid/ready handshake with opcode, handle, amount
// depends on gha_pkg
`timescale 1ns / 1ps

interface gha_req_if;
	logic                          valid;
	logic                          ready;
	logic [gha_pkg::OP_W-1:0]      opcode;
	logic [gha_pkg::HANDLE_W-1:0]  handle;
	logic [gha_pkg::AMOUNT_W-1:0]  amount;

	modport source (output valid, output opcode, output handle, output amount, input ready);
	modport sink (input valid, input opcode, input handle, input amount, output ready);
endinterface

/* hw/rtl/gha_rsp_if.sv */
// gha_rsp_if: result channel, valid/ready handshake with status and entry report
// depends on gha_pkg
`timescale 1ns / 1ps

interface gha_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gha_pkg::STATUS_W-1:0]  status;
	logic [gha_pkg::HANDLE_W-1:0]  new_handle;
	logic                          entry_valid;
	logic [gha_pkg::AMOUNT_W-1:0]  entry_size;
	logic                          entry_locked;
	logic [gha_pkg::USAGE_W-1:0]   usage_total;
	logic [gha_pkg::USAGE_W-1:0]   usage_peak;

	modport source (output valid, output status, output new_handle, output entry_valid,
		output entry_size, output entry_locked, output usage_total, output usage_peak,
		input ready);
	modport sink (input valid, input status, input new_handle, input entry_valid,
		input entry_size, input entry_locked, input usage_total, input usage_peak,
		output ready);
endinterface

/* hw/rtl/gha_search.sv */
// gha_search: rotating first-free search over the used-mark vector
// registered per-group stage, then group pick; depends on gha_pkg
`timescale 1ns / 1ps

module gha_search (
	input  logic                         clk,
	input  logic                         capture,
	input  logic [gha_pkg::SLOTS-1:0]    used,
	input  logic [gha_pkg::SLOT_W-1:0]   ptr,
	output logic                         found,
	output logic [gha_pkg::SLOT_W-1:0]   slot
);

	logic [gha_pkg::SLOT_W-1:0] start;
	logic [gha_pkg::GRP_N-1:0]  m_any, f_any;
	logic [gha_pkg::POS_W-1:0]  m_pos [gha_pkg::GRP_N];
	logic [gha_pkg::POS_W-1:0]  f_pos [gha_pkg::GRP_N];
	logic [gha_pkg::GRP_N-1:0]  m_any_q, f_any_q;
	logic [gha_pkg::POS_W-1:0]  m_pos_q [gha_pkg::GRP_N];
	logic [gha_pkg::POS_W-1:0]  f_pos_q [gha_pkg::GRP_N];

	assign start = ptr + 1'b1;

	// lowest free bit per group, both in the part at or after start and overall
	always_comb begin
		for (int g = 0; g < gha_pkg::GRP_N; g++) begin
			m_any[g] = 1'b0;
			f_any[g] = 1'b0;
			m_pos[g] = '0;
			f_pos[g] = '0;
			for (int b = gha_pkg::GRP_SZ - 1; b >= 0; b--) begin
				if (!used[g * gha_pkg::GRP_SZ + b]) begin
					f_any[g] = 1'b1;
					f_pos[g] = gha_pkg::POS_W'(b);
					if (gha_pkg::SLOT_W'(g * gha_pkg::GRP_SZ + b) >= start) begin
						m_any[g] = 1'b1;
						m_pos[g] = gha_pkg::POS_W'(b);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			m_any_q <= m_any;
			f_any_q <= f_any;
			m_pos_q <= m_pos;
			f_pos_q <= f_pos;
		end
	end

	// wrap to the lowest free slot when nothing is free past the pointer
	always_comb begin
		found = 1'b0;
		slot  = '0;
		for (int g = gha_pkg::GRP_N - 1; g >= 0; g--) begin
			if (f_any_q[g]) begin
				found = 1'b1;
				slot  = {gha_pkg::GRP_W'(g), f_pos_q[g]};
			end
		end
		for (int g = gha_pkg::GRP_N - 1; g >= 0; g--) begin
			if (m_any_q[g]) begin
				slot = {gha_pkg::GRP_W'(g), m_pos_q[g]};
			end
		end
	end

endmodule

/* hw/rtl/gha_ctrl.sv */
// gha_ctrl: two-state sequencer, capture then execute and write back
// depends on gha_pkg command and status structs
`timescale 1ns / 1ps

module gha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gha_pkg::sts_t   sts,
	output gha_pkg::cmd_t   cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready    = ready_q;
	assign cmd.capture = in_valid && ready_q;
	assign cmd.exec    = (state_q == S_EXEC) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/gha_datapath.sv */
// gha_datapath: handle table memories, used marks, usage counters, result register
// depends on gha_pkg and gha_search
`timescale 1ns / 1ps

module gha_datapath #(
	parameter int GEN_BITS  = 16,
	parameter int SIZE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gha_pkg::cmd_t                 cmd,
	output gha_pkg::sts_t                 sts,
	input  logic [gha_pkg::OP_W-1:0]      opcode,
	input  logic [gha_pkg::HANDLE_W-1:0]  handle,
	input  logic [gha_pkg::AMOUNT_W-1:0]  amount,
	input  logic                          out_ready,
	output logic                          out_valid,
	output gha_pkg::status_t              status,
	output logic [gha_pkg::HANDLE_W-1:0]  new_handle,
	output logic                          entry_valid,
	output logic [gha_pkg::AMOUNT_W-1:0]  entry_size,
	output logic                          entry_locked,
	output logic [gha_pkg::USAGE_W-1:0]   usage_total,
	output logic [gha_pkg::USAGE_W-1:0]   usage_peak
);

	localparam int CMP_W = (GEN_BITS > gha_pkg::HGEN_W) ? GEN_BITS : gha_pkg::HGEN_W;
	localparam int CAT_W = GEN_BITS + gha_pkg::SLOT_W;

	// table storage; a read counts as a hit only while the slot's used mark is set
	logic [GEN_BITS-1:0]        gen_mem  [gha_pkg::SLOTS];
	logic [SIZE_BITS-1:0]       bytes_mem[gha_pkg::SLOTS];
	logic [gha_pkg::LOCK_W-1:0] lock_mem [gha_pkg::SLOTS];

	logic [gha_pkg::SLOTS-1:0]   used_q;
	logic [gha_pkg::SLOT_W-1:0]  ptr_q;
	logic [GEN_BITS-1:0]         gen_ctr_q;
	logic [gha_pkg::USAGE_W-1:0] sum_q, peak_q;
	logic                        out_valid_q;

	gha_pkg::opcode_t            op_q;
	logic [gha_pkg::HANDLE_W-1:0] handle_q;
	logic [SIZE_BITS-1:0]        amount_q;
	logic                        used_hit_q;
	logic [GEN_BITS-1:0]         rd_gen_q;
	logic [SIZE_BITS-1:0]        rd_bytes_q;
	logic [gha_pkg::LOCK_W-1:0]  rd_lock_q;

	logic [gha_pkg::SLOT_W-1:0]  in_slot, slot_q, f_slot;
	logic                        f_found;
	logic                        hit;
	logic [GEN_BITS-1:0]         gen_nxt;
	logic [CAT_W-1:0]            cat;
	logic [gha_pkg::HANDLE_W-1:0] nh_alloc;
	logic                        alloc_valid;
	logic [gha_pkg::USAGE_W-1:0] sum_minus;

	gha_pkg::status_t            st;
	logic [gha_pkg::HANDLE_W-1:0] nh;
	logic                        rv;
	logic [SIZE_BITS-1:0]        rsz;
	logic [gha_pkg::LOCK_W-1:0]  rlk;
	logic                        wr_en, set_used, clr_used, pk;
	logic [gha_pkg::SLOT_W-1:0]  wr_slot, ptr_n;
	logic [GEN_BITS-1:0]         wr_gen, genc_n;
	logic [SIZE_BITS-1:0]        wr_bytes;
	logic [gha_pkg::LOCK_W-1:0]  wr_lock;
	logic [gha_pkg::USAGE_W-1:0] sum_n;

	gha_search u_search (
		.clk     (clk),
		.capture (cmd.capture),
		.used    (used_q),
		.ptr     (ptr_q),
		.found   (f_found),
		.slot    (f_slot)
	);

	assign in_slot = handle[gha_pkg::SLOT_W-1:0];
	assign slot_q  = handle_q[gha_pkg::SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= gha_pkg::opcode_t'(opcode);
			handle_q   <= handle;
			amount_q   <= SIZE_BITS'(amount);
			used_hit_q <= used_q[in_slot];
			rd_gen_q   <= gen_mem[in_slot];
			rd_bytes_q <= bytes_mem[in_slot];
			rd_lock_q  <= lock_mem[in_slot];
		end
		if (wr_en && cmd.exec) begin
			gen_mem[wr_slot]   <= wr_gen;
			bytes_mem[wr_slot] <= wr_bytes;
			lock_mem[wr_slot]  <= wr_lock;
		end
	end

	assign hit = used_hit_q &&
		(CMP_W'(rd_gen_q) == CMP_W'(handle_q[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_W]));
	assign gen_nxt  = gen_ctr_q + 1'b1;
	assign cat      = {gen_nxt, f_slot};
	assign nh_alloc = gha_pkg::HANDLE_W'(cat);
	// a generation cut off in the handle no longer validates
	assign alloc_valid = CMP_W'(gen_nxt) ==
		CMP_W'(nh_alloc[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_W]);
	assign sum_minus = sum_q - gha_pkg::USAGE_W'(rd_bytes_q);

	always_comb begin
		st       = gha_pkg::ST_OK;
		nh       = '0;
		rv       = hit;
		rsz      = rd_bytes_q;
		rlk      = rd_lock_q;
		wr_en    = 1'b0;
		wr_slot  = slot_q;
		wr_gen   = rd_gen_q;
		wr_bytes = rd_bytes_q;
		wr_lock  = rd_lock_q;
		set_used = 1'b0;
		clr_used = 1'b0;
		pk       = 1'b0;
		sum_n    = sum_q;
		ptr_n    = ptr_q;
		genc_n   = gen_ctr_q;
		case (op_q)
			gha_pkg::OP_ALLOC: begin
				if (f_found) begin
					wr_en    = 1'b1;
					wr_slot  = f_slot;
					wr_gen   = gen_nxt;
					wr_bytes = amount_q;
					wr_lock  = '0;
					set_used = 1'b1;
					sum_n    = sum_q + gha_pkg::USAGE_W'(amount_q);
					pk       = 1'b1;
					ptr_n    = f_slot;
					genc_n   = gen_nxt;
					nh       = nh_alloc;
					rv       = alloc_valid;
					rsz      = amount_q;
					rlk      = '0;
				end else begin
					st = gha_pkg::ST_NO_FREE;
				end
			end
			gha_pkg::OP_FREE: begin
				if (!hit) begin
					st = gha_pkg::ST_BAD_HANDLE;
				end else begin
					clr_used = 1'b1;
					sum_n    = sum_minus;
					rv       = 1'b0;
					if (rd_lock_q != '0) st = gha_pkg::ST_FREED_LOCKED;
				end
			end
			gha_pkg::OP_RESIZE: begin
				if (!hit) begin
					st = gha_pkg::ST_BAD_HANDLE;
				end else if (rd_lock_q != '0) begin
					st = gha_pkg::ST_LOCKED;
				end else begin
					wr_en    = 1'b1;
					wr_bytes = amount_q;
					sum_n    = sum_minus + gha_pkg::USAGE_W'(amount_q);
					pk       = 1'b1;
					rsz      = amount_q;
				end
			end
			gha_pkg::OP_LOCK: begin
				if (!hit) begin
					st = gha_pkg::ST_BAD_HANDLE;
				end else if (rd_lock_q == gha_pkg::LOCK_MAX) begin
					st = gha_pkg::ST_LOCK_SAT;
				end else begin
					wr_en   = 1'b1;
					wr_lock = rd_lock_q + 1'b1;
					rlk     = wr_lock;
				end
			end
			gha_pkg::OP_UNLOCK: begin
				if (!hit) begin
					st = gha_pkg::ST_BAD_HANDLE;
				end else if (rd_lock_q == '0) begin
					st = gha_pkg::ST_NOT_LOCKED;
				end else begin
					wr_en   = 1'b1;
					wr_lock = rd_lock_q - 1'b1;
					rlk     = wr_lock;
				end
			end
			gha_pkg::OP_INSPECT: begin
				if (!hit) st = gha_pkg::ST_BAD_HANDLE;
			end
			default: begin
			end
		endcase
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			ptr_q       <= '0;
			gen_ctr_q   <= GEN_BITS'(1);
			sum_q       <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (set_used) used_q[wr_slot] <= 1'b1;
				if (clr_used) used_q[slot_q] <= 1'b0;
				ptr_q     <= ptr_n;
				gen_ctr_q <= genc_n;
				sum_q     <= sum_n;
				if (pk && (sum_n > peak_q)) peak_q <= sum_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status       <= st;
			new_handle   <= nh;
			entry_valid  <= rv;
			entry_size   <= rv ? gha_pkg::AMOUNT_W'(rsz) : '0;
			entry_locked <= rv && (rlk != '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign usage_total = sum_q;
	assign usage_peak  = peak_q;

endmodule

/* hw/rtl/generational_handle_allocator.sv */
// result: table read registered at capture, then the write-back fills the result register
// requests: no new request is taken until the previous one has written back, as set by the
//   read-modify-write of the table memory and the registered group stage of the free-slot search
// a result may wait in the output register while the next request is taken
// reset: used marks, search pointer, usage and peak cleared, generation counter set to one
`timescale 1ns / 1ps

module generational_handle_allocator #(
	parameter int GEN_BITS  = 16,
	parameter int SIZE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	gha_req_if.sink   req,
	gha_rsp_if.source rsp
);

	gha_pkg::cmd_t    cmd;
	gha_pkg::sts_t    sts;
	gha_pkg::status_t status;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gha_datapath #(
		.GEN_BITS  (GEN_BITS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (req.opcode),
		.handle       (req.handle),
		.amount       (req.amount),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.status       (status),
		.new_handle   (rsp.new_handle),
		.entry_valid  (rsp.entry_valid),
		.entry_size   (rsp.entry_size),
		.entry_locked (rsp.entry_locked),
		.usage_total  (rsp.usage_total),
		.usage_peak   (rsp.usage_peak)
	);

	assign rsp.status = status;

	// one request at a time through the table
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous one still executing");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.usage_peak >= rsp.usage_total)
		else $error("peak usage below current usage");

	a_bad_not_live: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (status == gha_pkg::ST_BAD_HANDLE)) |->
		(!rsp.entry_valid && !rsp.entry_locked && (rsp.entry_size == '0)))
		else $error("bad handle reported as live entry");

	a_no_free_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (status != gha_pkg::ST_OK)) |-> (rsp.new_handle == '0))
		else $error("handle given out by a failed item");

endmodule
